// File: rtl/core/ddscsp_pkg.sv
// Shared codes, reset values and the sine table generator for the DDS sound player.
package ddscsp_pkg;

   // Transaction command codes
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK    = 2'd0;
   localparam cmd_type CMD_PLAY    = 2'd1;
   localparam cmd_type CMD_REC_ON  = 2'd2;
   localparam cmd_type CMD_REC_OFF = 2'd3;

   // Sound selector codes
   typedef logic [1:0] sound_type;
   localparam sound_type SOUND_SWOOP   = 2'd0;
   localparam sound_type SOUND_CHIRP   = 2'd1;
   localparam sound_type SOUND_SILENCE = 2'd2;
   localparam sound_type SOUND_NONE    = 2'd3;

   // Control register indexes
   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_SOUND_LENGTH = 3'd0;
   localparam csr_idx_type CSR_RAMP_LENGTH  = 3'd1;
   localparam csr_idx_type CSR_RAMP_SLOPE   = 3'd2;
   localparam csr_idx_type CSR_HZ_INCR      = 3'd3;
   localparam csr_idx_type CSR_CHIRP_START  = 3'd4;
   localparam csr_idx_type CSR_CHIRP_RATE   = 3'd5;
   localparam csr_idx_type CSR_SWOOP_CENTER = 3'd6;
   localparam csr_idx_type CSR_SWOOP_DEPTH  = 3'd7;

   // Control register reset values
   localparam logic [12:0] SOUND_LENGTH_RST = 13'd5720;
   localparam logic [12:0] RAMP_LENGTH_RST  = 13'd1000;
   localparam logic [20:0] RAMP_SLOPE_RST   = 21'd1049;
   localparam logic [31:0] HZ_INCR_RST      = 32'd97613;
   localparam logic [15:0] CHIRP_START_RST  = 16'd2000;
   localparam logic [23:0] CHIRP_RATE_RST   = 24'd5134;
   localparam logic [15:0] SWOOP_CENTER_RST = 16'd1740;
   localparam logic [15:0] SWOOP_DEPTH_RST  = 16'd260;

   // Output word and gain constants
   localparam logic [15:0] DAC_CMD     = 16'h3000;
   localparam logic [11:0] DAC_MIDCODE = 12'd2048;
   localparam logic [20:0] AMP_ONE     = 21'h100000;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;

   // 2047*sin(2*pi*idx/2^addr_bits), Q30 Taylor series on the folded angle
   function automatic logic signed [11:0] sine_entry(input int unsigned addr_bits,
                                                      input int unsigned idx);
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [11:0] m;
      logic        neg;
      t = 64'(idx) << (32 - addr_bits);
      neg = 1'b0;
      if (t >= 64'h8000_0000) begin
         neg = 1'b1;
         t = t - 64'h8000_0000;
      end
      if (t > 64'h4000_0000) begin
         t = 64'h8000_0000 - t;
      end
      x = (t * PI_Q30) >> 31;
      x2 = (x * x) >> 30;
      term = ((x * x2) >> 30) / 64'd6;
      sum = x - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - term;
      v = (64'd2047 * sum) >> 30;
      if (v > 64'd2047) begin
         v = 64'd2047;
      end
      m = v[11:0];
      return neg ? -m : m;
   endfunction

endpackage

// File: rtl/core/ddscsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ddscsp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/dds_chirp_sound_player_core.sv
// Play and record transactions take effect in the accepting cycle.
// A sample tick is shortest for silence or an idle player, longer for a chirp and longest for a
// swoop; the shared 32x24 multiplier and the one-bit-per-cycle divider that finds the swoop sine
// position set the difference, and the tick holds in its output step until the register is free.
// A finished sample waits in the output register while the next transaction is accepted.
// Reset is synchronous; there is no clearing pass, the record store is undefined until written.
module dds_chirp_sound_player_core
   import ddscsp_pkg::*;
#(
   parameter int SINE_DEPTH   = 256,
   parameter int RECORD_DEPTH = 64,
   parameter int DAC_BITS     = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_sound_select,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_dac_word,
   output logic        rsp_sound_active,
   // control register write port
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Derived sizes
   localparam int SINE_AW  = $clog2(SINE_DEPTH);
   localparam int J_W      = SINE_AW - 1;
   localparam int CNT_W    = $clog2(J_W);
   localparam int REC_AW   = $clog2(RECORD_DEPTH);
   localparam int DAC_UP   = (DAC_BITS >= 12) ? (DAC_BITS - 12) : 0;
   localparam int DAC_DOWN = (DAC_BITS < 12) ? (12 - DAC_BITS) : 0;
   localparam logic [15:0] DAC_MASK = 16'((1 << DAC_BITS) - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(J_W - 1);
   localparam logic [REC_AW-1:0] REC_LIMIT = REC_AW'(RECORD_DEPTH - 1);

   // Sequencer state codes
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_START     = 5'd1;
   localparam logic [4:0] S_EVAL      = 5'd2;
   localparam logic [4:0] S_DIV       = 5'd3;
   localparam logic [4:0] S_SIN_RD    = 5'd4;
   localparam logic [4:0] S_SIN_MUL   = 5'd5;
   localparam logic [4:0] S_DEV_A     = 5'd6;
   localparam logic [4:0] S_DEV_B     = 5'd7;
   localparam logic [4:0] S_FREQ      = 5'd8;
   localparam logic [4:0] S_CHIRP_MUL = 5'd9;
   localparam logic [4:0] S_CHIRP_ADD = 5'd10;
   localparam logic [4:0] S_INC_LO    = 5'd11;
   localparam logic [4:0] S_INC_HI    = 5'd12;
   localparam logic [4:0] S_INC_ADD   = 5'd13;
   localparam logic [4:0] S_ROM       = 5'd14;
   localparam logic [4:0] S_AMP       = 5'd15;
   localparam logic [4:0] S_SCALE     = 5'd16;
   localparam logic [4:0] S_OUT       = 5'd17;

   // Sine table, built at elaboration
   typedef logic [SINE_DEPTH-1:0][11:0] rom_type;

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         rom[i] = sine_entry(SINE_AW, i);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Offset sample to DAC command word
   function automatic logic [15:0] dac_code(input logic [11:0] offset);
      logic [15:0] v;
      v = ({4'b0, offset} << DAC_UP) >> DAC_DOWN;
      return DAC_CMD | (v & DAC_MASK);
   endfunction

   // Control registers
   logic [12:0] sound_len_ff, sound_len_in;
   logic [12:0] ramp_len_ff, ramp_len_in;
   logic [20:0] ramp_slope_ff, ramp_slope_in;
   logic [31:0] hz_incr_ff, hz_incr_in;
   logic [15:0] chirp_start_ff, chirp_start_in;
   logic [23:0] chirp_rate_ff, chirp_rate_in;
   logic [15:0] swoop_center_ff, swoop_center_in;
   logic [15:0] swoop_depth_ff, swoop_depth_in;

   // Player state
   logic [4:0]        state_ff, state_in;
   logic [31:0]       phase_ff, phase_in;
   logic [12:0]       tick_ff, tick_in;
   logic [1:0]        sound_ff, sound_in;
   logic [31:0]       chirp_ff, chirp_in;
   logic [REC_AW-1:0] count_ff, count_in;
   logic [REC_AW-1:0] pos_ff, pos_in;
   logic              mode_ff, mode_in;
   logic              idle_ff, idle_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic              active_ff, active_in;
   logic [12:0]       rem_ff, rem_in;
   logic [J_W-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [55:0]       prod_ff;
   logic signed [11:0] rom_ff;
   logic [21:0]       qd_ff, qd_in;
   logic [31:0]       dev_ff, dev_in;
   logic [32:0]       freq_ff, freq_in;
   logic [31:0]       inc_ff, inc_in;
   logic [20:0]       amp_ff, amp_in;
   logic [15:0]       rsp_dac_ff, rsp_dac_in;
   logic              rsp_active_ff, rsp_active_in;

   // Shared unit and helpers
   logic [31:0]        mul_a;
   logic [23:0]        mul_b;
   logic               mul_en;
   logic [55:0]        mul_prod;
   logic [SINE_AW-1:0] rom_addr;
   logic               ram_we;
   logic [1:0]         ram_rd;
   logic [13:0]        div_shift;
   logic               div_ge;
   logic [12:0]        div_rem;
   logic [31:0]        dev_y;
   logic [32:0]        dev_sum;
   logic [33:0]        dev_r;
   logic               dev_fix;
   logic [31:0]        chirp_next;
   logic [20:0]        amp_sat;
   logic [11:0]        rom_neg;
   logic [10:0]        mag;
   logic [10:0]        scaled;
   logic [11:0]        offset;
   logic               out_free;

   // Recorded play commands
   ddscsp_ram #(
      .WIDTH (2),
      .DEPTH (RECORD_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (req_sound_select),
      .rd_addr (pos_ff),
      .rd_data (ram_rd)
   );

   // Swoop position divider step: shift remainder, subtract length when it fits
   assign div_shift = {rem_ff, 1'b0};
   assign div_ge    = div_shift >= {1'b0, sound_len_ff};
   assign div_rem   = div_ge ? 13'(div_shift - {1'b0, sound_len_ff}) : div_shift[12:0];

   // Deviation: depth*sin*65536/2047 = 32p + floor(32p/2047), estimate then correct once
   assign dev_y   = {prod_ff[26:0], 5'b0};
   assign dev_sum = {1'b0, dev_y} + 33'(dev_y >> 11) + 33'(dev_y >> 22);
   assign dev_r   = {2'b0, dev_y} + 34'(qd_ff) - {1'b0, qd_ff, 11'b0};
   assign dev_fix = dev_r >= 34'd2047;

   // Chirp integrator step
   assign chirp_next = chirp_ff + 32'(prod_ff[36:8]);

   // Ramp gain saturates at unity
   assign amp_sat = (prod_ff[33:0] > 34'(AMP_ONE)) ? AMP_ONE : prod_ff[20:0];

   // Sign-magnitude sample and offset code
   assign rom_neg = 12'(-rom_ff);
   assign mag     = rom_ff[11] ? rom_neg[10:0] : rom_ff[10:0];
   assign scaled  = prod_ff[30:20];
   assign offset  = rom_ff[11] ? 12'(DAC_MIDCODE - {1'b0, scaled})
                               : 12'(DAC_MIDCODE + {1'b0, scaled});

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Select multiplier operands and the table address per step
   always_comb begin
      mul_a = 32'b0;
      mul_b = 24'b0;
      mul_en = 1'b0;
      rom_addr = phase_ff[31 -: SINE_AW];
      case (state_ff)
         S_SIN_RD: begin
            rom_addr = {1'b0, quot_ff};
         end
         S_SIN_MUL: begin
            mul_a = {16'b0, swoop_depth_ff};
            mul_b = {13'b0, rom_ff[10:0]};
            mul_en = 1'b1;
         end
         S_CHIRP_MUL: begin
            mul_a = {8'b0, chirp_rate_ff};
            mul_b = {11'b0, tick_ff};
            mul_en = 1'b1;
         end
         S_INC_LO: begin
            mul_a = hz_incr_ff;
            mul_b = {8'b0, freq_ff[15:0]};
            mul_en = 1'b1;
         end
         S_INC_HI: begin
            mul_a = hz_incr_ff;
            mul_b = {7'b0, freq_ff[32:16]};
            mul_en = 1'b1;
         end
         S_ROM: begin
            mul_a = {11'b0, ramp_slope_ff};
            mul_b = {11'b0, tick_ff};
            mul_en = 1'b1;
         end
         S_SCALE: begin
            mul_a = {11'b0, amp_ff};
            mul_b = {13'b0, mag};
            mul_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign mul_prod = {24'b0, mul_a} * {32'b0, mul_b};

   // Sequencer and next-state logic
   always_comb begin
      sound_len_in = sound_len_ff;
      ramp_len_in = ramp_len_ff;
      ramp_slope_in = ramp_slope_ff;
      hz_incr_in = hz_incr_ff;
      chirp_start_in = chirp_start_ff;
      chirp_rate_in = chirp_rate_ff;
      swoop_center_in = swoop_center_ff;
      swoop_depth_in = swoop_depth_ff;
      state_in = state_ff;
      phase_in = phase_ff;
      tick_in = tick_ff;
      sound_in = sound_ff;
      chirp_in = chirp_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      mode_in = mode_ff;
      idle_in = idle_ff;
      rsp_valid_in = rsp_valid_ff;
      active_in = active_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      qd_in = qd_ff;
      dev_in = dev_ff;
      freq_in = freq_ff;
      inc_in = inc_ff;
      amp_in = amp_ff;
      rsp_dac_in = rsp_dac_ff;
      rsp_active_in = rsp_active_ff;
      ram_we = 1'b0;

      // Write control registers
      if (csr_write) begin
         case (csr_index)
            CSR_SOUND_LENGTH: sound_len_in = csr_wdata[12:0];
            CSR_RAMP_LENGTH:  ramp_len_in = csr_wdata[12:0];
            CSR_RAMP_SLOPE:   ramp_slope_in = csr_wdata[20:0];
            CSR_HZ_INCR:      hz_incr_in = csr_wdata;
            CSR_CHIRP_START:  chirp_start_in = csr_wdata[15:0];
            CSR_CHIRP_RATE:   chirp_rate_in = csr_wdata[23:0];
            CSR_SWOOP_CENTER: swoop_center_in = csr_wdata[15:0];
            CSR_SWOOP_DEPTH:  swoop_depth_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_TICK: begin
                     state_in = S_START;
                  end
                  CMD_PLAY: begin
                     if (req_sound_select != SOUND_NONE) begin
                        tick_in = 13'd0;
                        sound_in = req_sound_select;
                        if (!mode_ff && (count_ff < REC_LIMIT)) begin
                           ram_we = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  CMD_REC_ON: begin
                     mode_in = 1'b0;
                     pos_in = '0;
                     count_in = '0;
                  end
                  CMD_REC_OFF: begin
                     mode_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            // Start the next recorded sound when the player has gone idle
            if (mode_ff && (pos_ff != count_ff) && idle_ff) begin
               sound_in = ram_rd;
               tick_in = 13'd0;
               pos_in = pos_ff + 1'b1;
               idle_in = 1'b0;
            end
            state_in = S_EVAL;
         end
         S_EVAL: begin
            active_in = tick_ff < sound_len_ff;
            if ((tick_ff < sound_len_ff) && (sound_ff == SOUND_SWOOP)) begin
               rem_in = tick_ff;
               cnt_in = '0;
               state_in = S_DIV;
            end else if ((tick_ff < sound_len_ff) && (sound_ff == SOUND_CHIRP)) begin
               state_in = S_CHIRP_MUL;
            end else begin
               state_in = S_ROM;
            end
         end
         S_DIV: begin
            rem_in = div_rem;
            quot_in = {quot_ff[J_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SIN_RD;
            end
         end
         S_SIN_RD: begin
            state_in = S_SIN_MUL;
         end
         S_SIN_MUL: begin
            state_in = S_DEV_A;
         end
         S_DEV_A: begin
            qd_in = dev_sum[32:11];
            state_in = S_DEV_B;
         end
         S_DEV_B: begin
            dev_in = dev_y + 32'(qd_ff) + 32'(dev_fix);
            state_in = S_FREQ;
         end
         S_FREQ: begin
            freq_in = {1'b0, swoop_center_ff, 16'b0} + {1'b0, dev_ff};
            state_in = S_INC_LO;
         end
         S_CHIRP_MUL: begin
            state_in = S_CHIRP_ADD;
         end
         S_CHIRP_ADD: begin
            chirp_in = chirp_next;
            freq_in = {1'b0, chirp_next};
            state_in = S_INC_LO;
         end
         S_INC_LO: begin
            state_in = S_INC_HI;
         end
         S_INC_HI: begin
            inc_in = prod_ff[47:16];
            state_in = S_INC_ADD;
         end
         S_INC_ADD: begin
            phase_in = phase_ff + inc_ff + prod_ff[31:0];
            state_in = S_ROM;
         end
         S_ROM: begin
            state_in = S_AMP;
         end
         S_AMP: begin
            amp_in = (tick_ff < ramp_len_ff) ? amp_sat : AMP_ONE;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_active_in = active_ff;
               if (active_ff && (sound_ff != SOUND_SILENCE)) begin
                  rsp_dac_in = dac_code(offset);
               end else begin
                  rsp_dac_in = dac_code(DAC_MIDCODE);
               end
               if (active_ff) begin
                  tick_in = tick_ff + 1'b1;
               end else begin
                  chirp_in = {chirp_start_ff, 16'b0};
                  idle_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sound_len_ff <= SOUND_LENGTH_RST;
         ramp_len_ff <= RAMP_LENGTH_RST;
         ramp_slope_ff <= RAMP_SLOPE_RST;
         hz_incr_ff <= HZ_INCR_RST;
         chirp_start_ff <= CHIRP_START_RST;
         chirp_rate_ff <= CHIRP_RATE_RST;
         swoop_center_ff <= SWOOP_CENTER_RST;
         swoop_depth_ff <= SWOOP_DEPTH_RST;
         state_ff <= S_IDLE;
         phase_ff <= 32'd0;
         tick_ff <= SOUND_LENGTH_RST;
         sound_ff <= SOUND_SWOOP;
         chirp_ff <= {CHIRP_START_RST, 16'b0};
         count_ff <= '0;
         pos_ff <= '0;
         mode_ff <= 1'b1;
         idle_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         sound_len_ff <= sound_len_in;
         ramp_len_ff <= ramp_len_in;
         ramp_slope_ff <= ramp_slope_in;
         hz_incr_ff <= hz_incr_in;
         chirp_start_ff <= chirp_start_in;
         chirp_rate_ff <= chirp_rate_in;
         swoop_center_ff <= swoop_center_in;
         swoop_depth_ff <= swoop_depth_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         sound_ff <= sound_in;
         chirp_ff <= chirp_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         mode_ff <= mode_in;
         idle_ff <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      active_ff <= active_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      cnt_ff <= cnt_in;
      qd_ff <= qd_in;
      dev_ff <= dev_in;
      freq_ff <= freq_in;
      inc_ff <= inc_in;
      amp_ff <= amp_in;
      rsp_dac_ff <= rsp_dac_in;
      rsp_active_ff <= rsp_active_in;
      rom_ff <= SINE_ROM[rom_addr];
      if (mul_en) begin
         prod_ff <= mul_prod;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dac_word     = rsp_dac_ff;
   assign rsp_sound_active = rsp_active_ff;

   // A response appears only out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside the output step");

   // Playback never runs past the recorded commands
   assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> pos_ff <= count_ff)
      else $error("playback position beyond record count");

   // Ramp gain never exceeds unity when applied
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCALE |-> amp_ff <= AMP_ONE)
      else $error("ramp gain above unity");

   // A new sample comes out only after the output register was free
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && rsp_stall |=> state_ff == S_OUT)
      else $error("sample overwrote a pending response");

endmodule
